// ----- src/e2r_pkg.sv -----
// Package for the Euler-angle to rotation-matrix block: widths, CORDIC constants,
// arctangent table and shared fixed-point helpers. No dependencies.
`default_nettype none
package e2r_pkg;
  localparam int AngleBits = 16;
  localparam int CoefFracBits = 14;
  localparam int WorkFrac = 30;
  localparam int CordicSteps = 30;
  localparam int OutBits = 16;
  localparam int WorkBits = 34;
  localparam int ZBits = 34;
  localparam logic signed [WorkBits-1:0] CordicGain = 34'sd652032874;

  typedef logic signed [WorkBits-1:0] work_t;
  typedef logic signed [ZBits-1:0] zang_t;

  typedef struct packed {
    work_t c;
    work_t s;
  } sincos_t;

  function automatic zang_t atan_lookup(input logic [4:0] i);
    zang_t r;
    case (i)
      5'd0: r = 34'sd536870912;
      5'd1: r = 34'sd316933406;
      5'd2: r = 34'sd167458907;
      5'd3: r = 34'sd85004756;
      5'd4: r = 34'sd42667331;
      5'd5: r = 34'sd21354465;
      5'd6: r = 34'sd10679838;
      5'd7: r = 34'sd5340245;
      5'd8: r = 34'sd2670163;
      5'd9: r = 34'sd1335087;
      5'd10: r = 34'sd667544;
      5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;
      5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;
      5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;
      5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;
      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;
      5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;
      5'd23: r = 34'sd81;
      5'd24: r = 34'sd41;
      5'd25: r = 34'sd20;
      5'd26: r = 34'sd10;
      5'd27: r = 34'sd5;
      5'd28: r = 34'sd3;
      5'd29: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Rounded Q4.30 product with a floor shift.
  function automatic work_t fmul(input work_t a, input work_t b);
    logic signed [2*WorkBits-1:0] p;
    p = a * b + (68'sd1 <<< (WorkFrac - 1));
    return work_t'(p >>> WorkFrac);
  endfunction
endpackage
`default_nettype wire

// ----- src/euler_to_rotation_matrix_top.sv -----
// Top level of the Euler-angle to rotation-matrix block with valid/stall
// channels. Depends on e2r_pkg, e2r_cordic and e2r_merge.
`default_nettype none
// Takes one angle triple per cycle and delivers one matrix per cycle while the
// output is not stalled. It holds a quadrant-reduction register, 30 CORDIC
// stages in each of three parallel lanes, then registers of products and rounding.
// The whole pipeline advances together and holds while the output is stalled.
module euler_to_rotation_matrix_top (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic signed [15:0] roll,
  input  wire logic signed [15:0] pitch,
  input  wire logic signed [15:0] yaw,
  output logic out_valid,
  input  wire logic out_stall,
  output logic signed [15:0] m00,
  output logic signed [15:0] m01,
  output logic signed [15:0] m02,
  output logic signed [15:0] m10,
  output logic signed [15:0] m11,
  output logic signed [15:0] m12,
  output logic signed [15:0] m20,
  output logic signed [15:0] m21,
  output logic signed [15:0] m22
);
  localparam int Lat = e2r_pkg::CordicSteps + 4;

  logic en;
  logic [Lat-1:0] vld;
  e2r_pkg::sincos_t cs_r, cs_p, cs_y;
  logic [e2r_pkg::OutBits-1:0] m [9];

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;
  assign out_valid = vld[Lat-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Lat-2:0], in_valid};
    end
  end

  e2r_cordic u_roll (.clk(clk), .en(en), .angle(roll), .result(cs_r));
  e2r_cordic u_pitch (.clk(clk), .en(en), .angle(pitch), .result(cs_p));
  e2r_cordic u_yaw (.clk(clk), .en(en), .angle(yaw), .result(cs_y));

  e2r_merge u_merge (.clk(clk), .en(en), .r(cs_r), .p(cs_p), .w(cs_y), .m(m));

  assign m00 = m[0];
  assign m01 = m[1];
  assign m02 = m[2];
  assign m10 = m[3];
  assign m11 = m[4];
  assign m12 = m[5];
  assign m20 = m[6];
  assign m21 = m[7];
  assign m22 = m[8];
endmodule
`default_nettype wire

// ----- src/e2r_cordic.sv -----
// One sine/cosine lane: quadrant reduction and a 30-stage pipelined CORDIC.
// Depends on e2r_pkg. Advances when en is high.
`default_nettype none
module e2r_cordic (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic [e2r_pkg::AngleBits-1:0] angle,
  output e2r_pkg::sincos_t result
);
  localparam int N = e2r_pkg::CordicSteps;

  e2r_pkg::work_t x [N+1];
  e2r_pkg::work_t y [N+1];
  e2r_pkg::zang_t z [N+1];
  logic [1:0] q [N+1];

  logic [31:0] phase;
  logic [1:0] q0;
  logic [31:0] res;

  always_comb begin
    phase = {angle, {(32-e2r_pkg::AngleBits){1'b0}}};
    q0 = 2'((phase + 32'h2000_0000) >> 30);
    res = phase - {q0, 30'd0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0] <= e2r_pkg::CordicGain;
      y[0] <= '0;
      z[0] <= e2r_pkg::zang_t'(signed'(res));
      q[0] <= q0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        q[i+1] <= q[i];
        if (!z[i][e2r_pkg::ZBits-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - e2r_pkg::atan_lookup(5'(i));
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + e2r_pkg::atan_lookup(5'(i));
        end
      end
    end
  end

  always_comb begin
    case (q[N])
      2'd0: begin result.c = x[N]; result.s = y[N]; end
      2'd1: begin result.c = -y[N]; result.s = x[N]; end
      2'd2: begin result.c = -x[N]; result.s = -y[N]; end
      default: begin result.c = y[N]; result.s = -x[N]; end
    endcase
  end
endmodule
`default_nettype wire

// ----- src/e2r_merge.sv -----
// Merging stage: combines the three sine/cosine lanes into the nine matrix entries
// by pairwise then triple products, then rounds and saturates. Depends on e2r_pkg.
`default_nettype none
module e2r_merge (
  input  wire logic clk,
  input  wire logic en,
  input  e2r_pkg::sincos_t r,
  input  e2r_pkg::sincos_t p,
  input  e2r_pkg::sincos_t w,
  output logic [e2r_pkg::OutBits-1:0] m [9]
);
  e2r_pkg::work_t srsp, crsp, crcy, crsy, srcy, srsy, crcp, srcp, cpsy, cpcy;
  e2r_pkg::work_t sp2, cy2, sy2;
  e2r_pkg::work_t a [9];

  function automatic logic [e2r_pkg::OutBits-1:0] finish(input e2r_pkg::work_t v);
    localparam int Sh = e2r_pkg::WorkFrac - e2r_pkg::CoefFracBits;
    localparam e2r_pkg::work_t Lim = e2r_pkg::work_t'(1) <<< e2r_pkg::CoefFracBits;
    e2r_pkg::work_t t;
    t = (v + (e2r_pkg::work_t'(1) <<< (Sh - 1))) >>> Sh;
    if (t > Lim) t = Lim;
    if (t < -Lim) t = -Lim;
    return t[e2r_pkg::OutBits-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      srsp <= e2r_pkg::fmul(r.s, p.s);
      crsp <= e2r_pkg::fmul(r.c, p.s);
      crcy <= e2r_pkg::fmul(r.c, w.c);
      crsy <= e2r_pkg::fmul(r.c, w.s);
      srcy <= e2r_pkg::fmul(r.s, w.c);
      srsy <= e2r_pkg::fmul(r.s, w.s);
      crcp <= e2r_pkg::fmul(r.c, p.c);
      srcp <= e2r_pkg::fmul(r.s, p.c);
      cpsy <= e2r_pkg::fmul(p.c, w.s);
      cpcy <= e2r_pkg::fmul(p.c, w.c);
      sp2 <= p.s;
      cy2 <= w.c;
      sy2 <= w.s;
      a[0] <= crcy - e2r_pkg::fmul(srsp, sy2);
      a[1] <= -srcp;
      a[2] <= crsy + e2r_pkg::fmul(srsp, cy2);
      a[3] <= srcy + e2r_pkg::fmul(crsp, sy2);
      a[4] <= crcp;
      a[5] <= srsy - e2r_pkg::fmul(crsp, cy2);
      a[6] <= -cpsy;
      a[7] <= sp2;
      a[8] <= cpcy;
      for (int k = 0; k < 9; k++) begin
        m[k] <= finish(a[k]);
      end
    end
  end
endmodule
`default_nettype wire
